[rtl/core/ptrd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptrd_pkg : shared types and helpers for the planar tile rle decoder
// Word layouts, parse phases, register indexes and the range clamps.
// ----------------------------------------------------------------------------
package ptrd_pkg;

   localparam int TILE_EDGE    = 64;
   localparam int MAX_CHANNELS = 4;

   localparam int CHAN_CFG_W = 3;
   localparam int EDGE_W     = 7;
   localparam int AREA_W     = 13;
   localparam int RUN_W      = 16;
   localparam int CHAN_IDX_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 2'd2;

   localparam logic [7:0]       LITERAL_BASE = 8'd128;
   localparam logic [RUN_W-1:0] LONG_MARK    = 16'd128;

   typedef enum logic [2:0] {
      PH_OPCODE,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_REPVAL,
      PH_LITERAL,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_tile;
   } req_type;

   typedef struct packed {
      logic [1:0]  channel;
      logic [11:0] pixel_start;
      logic [12:0] run_length;
      logic [7:0]  fill_value;
      logic        tile_done;
      logic        overrun;
   } rsp_type;

   typedef struct packed {
      logic [CHAN_CFG_W-1:0] channels_in_use;
      logic [EDGE_W-1:0]     tile_width;
      logic [EDGE_W-1:0]     tile_height;
   } cfg_type;

   function automatic logic [CHAN_CFG_W-1:0] clamp_channels(input logic [CHAN_CFG_W-1:0] v);
      logic [CHAN_CFG_W-1:0] r;
      if (v == '0) r = CHAN_CFG_W'(1);
      else if (v > CHAN_CFG_W'(MAX_CHANNELS)) r = CHAN_CFG_W'(MAX_CHANNELS);
      else r = v;
      return r;
   endfunction

   function automatic logic [EDGE_W-1:0] clamp_edge(input logic [EDGE_W-1:0] v);
      logic [EDGE_W-1:0] r;
      if (v == '0) r = EDGE_W'(1);
      else if (v > EDGE_W'(TILE_EDGE)) r = EDGE_W'(TILE_EDGE);
      else r = v;
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/core/ptrd_csr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptrd_csr : configuration registers
// Holds channel count and tile size; always ready for a write.
// ----------------------------------------------------------------------------
module ptrd_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ptrd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ptrd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output ptrd_pkg::cfg_type                     cfg
);
   import ptrd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CHANNELS: cfg_in.channels_in_use = csr_wdata[CHAN_CFG_W-1:0];
            CSR_WIDTH:    cfg_in.tile_width      = csr_wdata[EDGE_W-1:0];
            CSR_HEIGHT:   cfg_in.tile_height     = csr_wdata[EDGE_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channels_in_use <= CHAN_CFG_W'(MAX_CHANNELS);
         cfg_ff.tile_width      <= EDGE_W'(TILE_EDGE);
         cfg_ff.tile_height     <= EDGE_W'(TILE_EDGE);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/ptrd_in_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptrd_in_stage : input register
// Captures one compressed byte; moves on when the result side has room.
// ----------------------------------------------------------------------------
module ptrd_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ptrd_pkg::req_type req_data,
   input  wire logic              advance,
   output logic                   step,
   output ptrd_pkg::req_type      held
);
   import ptrd_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff;
   logic    accept;

   assign step      = valid_ff && advance;
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign held      = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) valid_in = 1'b1;
      else if (step) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) data_ff <= req_data;
   end

endmodule
`default_nettype wire

[rtl/core/ptrd_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptrd_parser : run-length parse state and write descriptor forming
// One byte per step: opcode, long length, repeat value or literal byte.
// ----------------------------------------------------------------------------
module ptrd_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire ptrd_pkg::req_type held,
   input  wire ptrd_pkg::cfg_type cfg,
   output logic                   emit,
   output ptrd_pkg::rsp_type      result
);
   import ptrd_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [RUN_W-1:0]      rr_ff, rr_in;
   logic                  lit_ff, lit_in;
   logic [7:0]            lhb_ff, lhb_in;
   logic [CHAN_IDX_W-1:0] ch_ff, ch_in;
   logic [AREA_W-1:0]     pos_ff, pos_in;
   logic [AREA_W-1:0]     ppc_ff, ppc_in;

   phase_type             cur_phase;
   logic [RUN_W-1:0]      cur_rr;
   logic                  cur_lit;
   logic [7:0]            cur_lhb;
   logic [CHAN_IDX_W-1:0] cur_ch;
   logic [AREA_W-1:0]     cur_pos;
   logic [AREA_W-1:0]     cur_ppc;

   logic [AREA_W-1:0]     area;
   logic [CHAN_CFG_W-1:0] nch;
   logic [AREA_W-1:0]     left;
   logic                  over;
   logic                  last_ch;
   logic [AREA_W-1:0]     count;
   logic [AREA_W:0]       pos_sum;
   logic [RUN_W-1:0]      run_len;
   logic                  load_run;
   logic                  end_run;
   logic [7:0]            b;

   assign b    = held.data_byte;
   assign area = AREA_W'(clamp_edge(cfg.tile_width)) * AREA_W'(clamp_edge(cfg.tile_height));
   assign nch  = clamp_channels(cfg.channels_in_use);

   always_comb begin
      // start of tile abandons whatever was in progress
      if (held.start_tile) begin
         cur_ppc   = area;
         cur_ch    = '0;
         cur_pos   = '0;
         cur_rr    = '0;
         cur_lit   = 1'b0;
         cur_lhb   = '0;
         cur_phase = PH_OPCODE;
      end else begin
         cur_ppc   = ppc_ff;
         cur_ch    = ch_ff;
         cur_pos   = pos_ff;
         cur_rr    = rr_ff;
         cur_lit   = lit_ff;
         cur_lhb   = lhb_ff;
         cur_phase = phase_ff;
      end

      left    = cur_ppc - cur_pos;
      over    = cur_rr > RUN_W'(left);
      last_ch = ({1'b0, cur_ch} + 4'd1) >= {1'b0, nch};
      count   = over ? left : cur_rr[AREA_W-1:0];

      phase_in = cur_phase;
      rr_in    = cur_rr;
      lit_in   = cur_lit;
      lhb_in   = cur_lhb;
      ch_in    = cur_ch;
      pos_in   = cur_pos;
      ppc_in   = cur_ppc;

      emit     = 1'b0;
      result   = '0;
      run_len  = '0;
      load_run = 1'b0;
      end_run  = 1'b0;
      pos_sum  = '0;

      if (cur_ppc != '0) begin
         case (cur_phase)
            PH_OPCODE: begin
               if (b >= LITERAL_BASE) begin
                  lit_in  = 1'b1;
                  run_len = RUN_W'(9'd256 - {1'b0, b});
               end else begin
                  lit_in  = 1'b0;
                  run_len = RUN_W'({1'b0, b} + 9'd1);
               end
               if (run_len == LONG_MARK) phase_in = PH_LEN_HI;
               else load_run = 1'b1;
            end
            PH_LEN_HI: begin
               lhb_in   = b;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               run_len  = {cur_lhb, b};
               load_run = 1'b1;
            end
            PH_REPVAL: begin
               if (cur_rr == '0) begin
                  phase_in = PH_OPCODE;
               end else begin
                  pos_sum = {1'b0, cur_pos} + {1'b0, count};
                  emit    = 1'b1;
                  result.channel     = cur_ch[1:0];
                  result.pixel_start = cur_pos[11:0];
                  result.run_length  = count;
                  result.fill_value  = b;
                  result.tile_done   = (pos_sum >= {1'b0, cur_ppc}) && last_ch;
                  result.overrun     = over;
                  pos_in  = pos_sum[AREA_W-1:0];
                  rr_in   = '0;
                  end_run = 1'b1;
               end
            end
            PH_LITERAL: begin
               if (cur_pos < cur_ppc) begin
                  pos_sum = {1'b0, cur_pos} + (AREA_W+1)'(1);
                  emit    = 1'b1;
                  result.channel     = cur_ch[1:0];
                  result.pixel_start = cur_pos[11:0];
                  result.run_length  = AREA_W'(1);
                  result.fill_value  = b;
                  result.tile_done   = (pos_sum >= {1'b0, cur_ppc}) && last_ch;
                  result.overrun     = over;
                  pos_in  = pos_sum[AREA_W-1:0];
               end
               // bytes past the channel end are swallowed
               rr_in = cur_rr - RUN_W'(1);
               if (rr_in == '0) end_run = 1'b1;
            end
            default: begin
               phase_in = cur_phase;
            end
         endcase
      end

      if (load_run) begin
         rr_in = run_len;
         if (!lit_in) phase_in = PH_REPVAL;
         else if (run_len == '0) phase_in = PH_OPCODE;
         else phase_in = PH_LITERAL;
      end

      if (end_run) begin
         phase_in = PH_OPCODE;
         if (pos_in >= cur_ppc) begin
            pos_in = '0;
            ch_in  = cur_ch + CHAN_IDX_W'(1);
            if (ch_in >= nch || ch_in == '0) phase_in = PH_DONE;
         end
      end

      if (!step) emit = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OPCODE;
         rr_ff    <= '0;
         lit_ff   <= 1'b0;
         lhb_ff   <= '0;
         ch_ff    <= '0;
         pos_ff   <= '0;
         ppc_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         rr_ff    <= rr_in;
         lit_ff   <= lit_in;
         lhb_ff   <= lhb_in;
         ch_ff    <= ch_in;
         pos_ff   <= pos_in;
         ppc_ff   <= ppc_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/ptrd_out_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptrd_out_stage : result register
// Holds one descriptor word until the consumer takes it.
// ----------------------------------------------------------------------------
module ptrd_out_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire ptrd_pkg::rsp_type result,
   output logic                   advance,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ptrd_pkg::rsp_type      rsp_data
);
   import ptrd_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // room when empty or when the held word leaves this cycle
   assign advance   = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      if (load) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= result;
   end

endmodule
`default_nettype wire

[rtl/core/planar_tile_rle_decoder_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// planar_tile_rle_decoder_core : planar tile run-length decoder
// Turns compressed tile bytes into pixel write descriptors per channel plane.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          word
//  req      in   req_valid/stall    data_byte, start_tile
//  rsp      out  rsp_valid/stall    channel, pixel_start, run_length, ...
//  csr      in   csr_valid/ready    csr_index, csr_wdata
//
//  One byte per cycle sustained unless the result side stalls. Any descriptor
//  a byte forms is registered into the result register as the byte leaves the
//  input register. The parse step (one small multiply for the tile area, one
//  subtract and compare) sets the cycle. Synchronous reset clears the parse
//  state; no byte is decoded until a start of tile. A stalled result holds the
//  input register, and the input stalls only while both registers are full.
// ----------------------------------------------------------------------------
module planar_tile_rle_decoder_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire ptrd_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output ptrd_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ptrd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ptrd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ptrd_pkg::*;

   cfg_type cfg;
   req_type held;
   rsp_type result;
   logic    advance;
   logic    step;
   logic    emit;

   ptrd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ptrd_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .advance   (advance),
      .step      (step),
      .held      (held)
   );

   ptrd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .held   (held),
      .cfg    (cfg),
      .emit   (emit),
      .result (result)
   );

   ptrd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .result    (result),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[rtl/core/ptrd_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptrd_checker : port-level checks for the tile decoder
// Watches the handshakes and descriptor words seen at the top level.
// ----------------------------------------------------------------------------
module ptrd_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire ptrd_pkg::rsp_type rsp_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall
);
   import ptrd_pkg::*;

   // a stalled word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result word changed while stalled");

   // input backs up only behind a full, stalled result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with room on the result side");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.run_length != 13'd0)
      else $error("descriptor with zero length");

   // a write never runs past the end of the largest plane
   a_in_plane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({2'b00, rsp_data.pixel_start} + {1'b0, rsp_data.run_length})
                    <= 14'd4096)
      else $error("descriptor runs past the tile");

endmodule

bind planar_tile_rle_decoder_core ptrd_checker u_ptrd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);
`default_nettype wire

[verif/tb_planar_tile_rle_decoder_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_planar_tile_rle_decoder_core : self-checking bench for the tile decoder
// Drives compressed tile bytes through the request channel and checks every
// write descriptor against a cycle-free decoder kept in step with each
// accepted word. It covers directed runs, register clamps, tile shapes from
// the smallest to the largest, random runs with noise and restarts, random
// idling on both channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_planar_tile_rle_decoder_core;
   import ptrd_pkg::*;

   localparam int CLOCK_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // decoder state as the bench sees it
   logic [2:0]  cfg_channels;
   logic [6:0]  cfg_width;
   logic [6:0]  cfg_height;
   phase_type   parse_phase;
   logic [15:0] run_left;
   bit          run_literal;
   logic [7:0]  length_hi;
   logic [2:0]  chan_idx;
   logic [12:0] pixel_pos;
   logic [12:0] plane_area;

   rsp_type pending_writes[$];
   int      mismatch_count = 0;
   int      bytes_sent     = 0;
   int      cycle_count    = 0;
   bit      quiet          = 1'b0;
   bit      start_next     = 1'b0;
   int      hold_requests  = 0;
   int      hold_served    = 0;
   int      hold_left      = 0;

   planar_tile_rle_decoder_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int limit_range(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void clear_decoder();
      cfg_channels = 3'd4;
      cfg_width    = 7'd64;
      cfg_height   = 7'd64;
      parse_phase  = PH_OPCODE;
      run_left     = '0;
      run_literal  = 1'b0;
      length_hi    = '0;
      chan_idx     = '0;
      pixel_pos    = '0;
      plane_area   = '0;
   endfunction

   // step to the next plane once the current one is full
   function automatic void close_run();
      parse_phase = PH_OPCODE;
      if (pixel_pos >= plane_area) begin
         pixel_pos = '0;
         chan_idx  = chan_idx + 3'd1;
         if (int'(chan_idx) >= limit_range(cfg_channels, MAX_CHANNELS) || chan_idx == 3'd0)
            parse_phase = PH_DONE;
      end
   endfunction

   function automatic void open_run(input int len);
      run_left = 16'(len);
      if (run_literal)
         parse_phase = (run_left == 16'd0) ? PH_OPCODE : PH_LITERAL;
      else
         parse_phase = PH_REPVAL;
   endfunction

   function automatic void record_write(input int count, input logic [7:0] value, input bit over);
      rsp_type w;
      w.channel     = chan_idx[1:0];
      w.pixel_start = pixel_pos[11:0];
      w.run_length  = 13'(count);
      w.fill_value  = value;
      w.tile_done   = (int'(pixel_pos) + count >= int'(plane_area))
                      && (int'(chan_idx) + 1 >= limit_range(cfg_channels, MAX_CHANNELS));
      w.overrun     = over;
      pending_writes.push_back(w);
   endfunction

   function automatic void decode_byte(input req_type w);
      int         len;
      int         left;
      logic [7:0] b;
      b = w.data_byte;
      if (w.start_tile) begin
         plane_area  = 13'(limit_range(cfg_width, TILE_EDGE) * limit_range(cfg_height, TILE_EDGE));
         chan_idx    = '0;
         pixel_pos   = '0;
         run_left    = '0;
         run_literal = 1'b0;
         length_hi   = '0;
         parse_phase = PH_OPCODE;
      end
      if (plane_area == 13'd0) return;
      left = int'(plane_area) - int'(pixel_pos);
      case (parse_phase)
         PH_OPCODE: begin
            run_literal = (b >= LITERAL_BASE);
            len = run_literal ? 256 - int'(b) : int'(b) + 1;
            if (len == int'(LONG_MARK)) parse_phase = PH_LEN_HI;
            else open_run(len);
         end
         PH_LEN_HI: begin
            length_hi   = b;
            parse_phase = PH_LEN_LO;
         end
         PH_LEN_LO: open_run(int'({length_hi, b}));
         PH_REPVAL: begin
            // a zero long length still eats its value byte
            if (run_left == 16'd0) begin
               parse_phase = PH_OPCODE;
            end else begin
               len = (int'(run_left) > left) ? left : int'(run_left);
               record_write(len, b, int'(run_left) > left);
               pixel_pos = pixel_pos + 13'(len);
               run_left  = '0;
               close_run();
            end
         end
         PH_LITERAL: begin
            // bytes past the plane end are swallowed without a write
            if (left > 0) begin
               record_write(1, b, int'(run_left) > left);
               pixel_pos = pixel_pos + 13'd1;
            end
            run_left = run_left - 16'd1;
            if (run_left == 16'd0) close_run();
         end
         default: ;
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] value, input bit restart);
      req_type w;
      w.data_byte  = value;
      w.start_tile = restart | start_next;
      start_next   = 1'b0;
      while (!quiet && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(w);
      bytes_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_CHANNELS: cfg_channels = value[2:0];
         CSR_WIDTH:    cfg_width    = value;
         CSR_HEIGHT:   cfg_height   = value;
         default: ;
      endcase
   endtask

   task automatic load_tile_shape(input int chans, input int w, input int h);
      // spare upper bits of the channel word are junk on purpose
      write_reg(CSR_CHANNELS, {4'($urandom_range(0, 15)), 3'(chans)});
      write_reg(CSR_WIDTH, 7'(w));
      write_reg(CSR_HEIGHT, 7'(h));
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_run();
      int kind;
      int len;
      int hi;
      int lo;
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
         send_byte(8'($urandom_range(0, 126)), 1'b0);
         send_byte(8'($urandom), 1'b0);
      end else if (kind == 4) begin
         hi = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 255);
         lo = $urandom_range(0, 255);
         if ($urandom_range(0, 7) == 0) begin
            hi = 0;
            lo = 0;
         end
         send_byte(8'd127, 1'b0);
         send_byte(8'(hi), 1'b0);
         send_byte(8'(lo), 1'b0);
         send_byte(8'($urandom), 1'b0);
      end else if (kind <= 7) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 12);
         send_byte(8'(256 - len), 1'b0);
         repeat (len) send_byte(8'($urandom), 1'b0);
      end else begin
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 400) : $urandom_range(0, 40);
         send_byte(LITERAL_BASE, 1'b0);
         send_byte(8'(len >> 8), 1'b0);
         send_byte(8'(len), 1'b0);
         repeat (len) send_byte(8'($urandom), 1'b0);
      end
   endtask

   task automatic random_traffic(input int n_words);
      int stop_at;
      stop_at    = bytes_sent + n_words;
      start_next = ($urandom_range(0, 3) != 0);
      while (bytes_sent < stop_at) begin
         if (parse_phase == PH_DONE) begin
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
            start_next = 1'b1;
         end
         if ($urandom_range(0, 99) < 6)
            send_byte(8'($urandom), $urandom_range(0, 7) == 0);
         else
            send_run();
      end
   endtask

   task automatic test_no_tile_open();
      repeat (6) send_byte(8'($urandom), 1'b0);
      wait_idle();
   endtask

   task automatic test_directed_runs();
      load_tile_shape(2, 2, 2);
      start_next = 1'b1;
      send_byte(8'd0, 1'b0);   send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);  send_byte(8'h00, 1'b0);
      // long repeat of one
      send_byte(8'd127, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h01, 1'b0);
      send_byte(8'hAA, 1'b0);
      // zero long literal, then zero long repeat
      send_byte(LITERAL_BASE, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
      send_byte(8'd127, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
      send_byte(8'h55, 1'b0);
      // literal crossing the plane end
      send_byte(8'd254, 1'b0); send_byte(8'h7E, 1'b0); send_byte(8'h81, 1'b0);
      // clamped repeat closes the tile, then trailing junk
      send_byte(8'd10, 1'b0);  send_byte(8'h80, 1'b0);
      send_byte(8'h3C, 1'b0);  send_byte(8'hC3, 1'b0);
      // restart in the middle of a literal
      send_byte(8'd253, 1'b1); send_byte(8'h11, 1'b0);
      send_byte(8'd3, 1'b1);   send_byte(8'h22, 1'b0);
      wait_idle();
   endtask

   task automatic test_extreme_shapes();
      load_tile_shape(1, 1, 1);
      random_traffic(200);
      wait_idle();
      load_tile_shape(4, 64, 64);
      random_traffic(200);
      wait_idle();
   endtask

   task automatic test_register_clamps();
      load_tile_shape(0, 0, 0);
      random_traffic(150);
      wait_idle();
      load_tile_shape(7, 127, 127);
      random_traffic(150);
      wait_idle();
   endtask

   task automatic test_random_tiles();
      quiet = 1'b1;
      load_tile_shape($urandom_range(1, 4), $urandom_range(1, 8), $urandom_range(1, 8));
      random_traffic(250);
      wait_idle();
      quiet = 1'b0;
      repeat (2) begin
         load_tile_shape($urandom_range(1, 4), $urandom_range(1, 8), $urandom_range(1, 8));
         random_traffic(225);
         wait_idle();
      end
   endtask

   task automatic test_result_hold_off();
      load_tile_shape($urandom_range(1, 4), $urandom_range(1, 8), $urandom_range(1, 8));
      hold_requests++;
      random_traffic(250);
      wait_idle();
   endtask

   // result side: random stalls, or one long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 24);
      end
   end

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_writes
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_writes.size() == 0) begin
            $display("%0t: unexpected word ch=%0d px=%0d len=%0d val=%0d done=%0d over=%0d",
                     $time, rsp_data.channel, rsp_data.pixel_start, rsp_data.run_length,
                     rsp_data.fill_value, rsp_data.tile_done, rsp_data.overrun);
            mismatch_count++;
         end else begin
            want = pending_writes.pop_front();
            compare_field("channel", want.channel, rsp_data.channel);
            compare_field("pixel_start", want.pixel_start, rsp_data.pixel_start);
            compare_field("run_length", want.run_length, rsp_data.run_length);
            compare_field("fill_value", want.fill_value, rsp_data.fill_value);
            compare_field("tile_done", want.tile_done, rsp_data.tile_done);
            compare_field("overrun", want.overrun, rsp_data.overrun);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CLOCK_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      clear_decoder();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_no_tile_open();
      test_directed_runs();
      test_extreme_shapes();
      test_register_clamps();
      test_random_tiles();
      test_result_hold_off();
      if (pending_writes.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, pending_writes.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
`default_nettype wire

[planar_tile_rle_decoder_core.f]
rtl/core/ptrd_pkg.sv
rtl/core/ptrd_csr.sv
rtl/core/ptrd_in_stage.sv
rtl/core/ptrd_parser.sv
rtl/core/ptrd_out_stage.sv
rtl/core/planar_tile_rle_decoder_core.sv
rtl/core/ptrd_checker.sv
verif/tb_planar_tile_rle_decoder_core.sv
